>>> rtl/rspool_pkg.sv
// Package: shared constants and types for the refcounted slot pool.
`timescale 1ns / 1ps
`default_nettype none
package rspool_pkg;
    localparam int SLOTS      = 32;
    localparam int SLOT_BITS  = 5;
    localparam int KEY_BITS   = 64;
    localparam int COUNT_BITS = 16;
    localparam int LIVE_BITS  = 6;
    localparam int QDEPTH     = 2;

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_KEYED   = 3'd1,
        MODE_RETAIN  = 3'd2,
        MODE_RELEASE = 3'd3,
        MODE_UNIQUE  = 3'd4,
        MODE_QUERY   = 3'd5,
        MODE_NOP6    = 3'd6,
        MODE_NOP7    = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_DEAD   = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    // Classified request handed from front to back.
    typedef struct packed {
        mode_t                 mode;
        logic [SLOT_BITS-1:0]  slot;
        logic                  keyed;
        logic [KEY_BITS-1:0]   key;
    } req_t;
endpackage
`default_nettype wire

>>> rtl/refcounted_slot_pool_with_key_sharing.sv
// Top level: refcounted slot pool with key sharing.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | mode, slot, key, key_present
//  out     | output    | out_valid/out_stall | result_slot, status, reused,
//          |           |                   | user_total, slot_freed, live_slots
//
// One request per cycle while in_stall is low; an accepted request passes through the
// front queue and then the back part's table update into the result register before
// out_valid rises.
// The key match is a parallel compare over all slots in the back part.
// Reset clears the queue, the live and shared marks and loads the free stack.
// A stalled out holds the result; the two-entry queue keeps taking input until full.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_slot_pool_with_key_sharing (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [4:0]  slot,
    input  wire logic [63:0] key,
    input  wire logic        key_present,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       result_slot,
    output logic [1:0]       status,
    output logic             reused,
    output logic [15:0]      user_total,
    output logic             slot_freed,
    output logic [5:0]       live_slots
);
    import rspool_pkg::*;

    logic q_valid, q_pop;
    req_t q_req;

    // Accept and classify the request, hold it in the queue.
    rspool_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .slot(slot), .key(key), .key_present(key_present),
        .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
    );

    // Carry out the request against the slot table and register the result.
    rspool_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_slot(result_slot), .status(status), .reused(reused),
        .user_total(user_total), .slot_freed(slot_freed), .live_slots(live_slots)
    );

`ifndef SYNTHESIS
    // A result still waiting must not be overwritten by a new transfer.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !q_pop)
        else $error("result overwritten while stalled");
    // The live count never exceeds the pool size.
    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        live_slots <= 6'(SLOTS))
        else $error("live count out of range");
    // A freed slot reports zero users.
    a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_freed |-> user_total == 16'd0 && status == ST_OK)
        else $error("freed slot with users");
`endif
endmodule
`default_nettype wire

>>> rtl/rspool_front.sv
// Front part: accept requests, classify them and queue them for the back part.
`timescale 1ns / 1ps
`default_nettype none
module rspool_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [2:0]                     mode,
    input  wire logic [rspool_pkg::SLOT_BITS-1:0] slot,
    input  wire logic [rspool_pkg::KEY_BITS-1:0]  key,
    input  wire logic                           key_present,
    output logic                                q_valid,
    output rspool_pkg::req_t                    q_req,
    input  wire logic                           q_pop
);
    import rspool_pkg::*;

    req_t       buf_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       cls;
    logic       push;

    always_comb
    begin
        cls.mode  = mode_t'(mode);
        cls.slot  = slot;
        cls.keyed = (mode_t'(mode) == MODE_KEYED) && key_present;
        cls.key   = key;
    end

    assign in_stall = (cnt_reg == 2'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rp_reg];

    always_comb
    begin
        wp_next  = push  ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= cls;
    end
endmodule
`default_nettype wire

>>> rtl/rspool_back.sv
// Back part: slot table, free stack and result register.
`timescale 1ns / 1ps
`default_nettype none
module rspool_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire rspool_pkg::req_t               q_req,
    output logic                                q_pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [rspool_pkg::SLOT_BITS-1:0]    result_slot,
    output logic [1:0]                          status,
    output logic                                reused,
    output logic [15:0]                         user_total,
    output logic                                slot_freed,
    output logic [rspool_pkg::LIVE_BITS-1:0]    live_slots
);
    import rspool_pkg::*;

    logic [SLOT_BITS-1:0]  stack_reg [SLOTS];
    logic [COUNT_BITS-1:0] cnt_reg   [SLOTS];
    logic [KEY_BITS-1:0]   key_reg   [SLOTS];
    logic [SLOTS-1:0]      live_reg, shared_reg;
    logic [LIVE_BITS-1:0]  fc_reg, fc_next;
    logic                  ov_reg;
    logic [SLOT_BITS-1:0]  rs_reg;
    logic [1:0]            st_reg;
    logic                  ru_reg, fr_reg;
    logic [15:0]           tot_reg;

    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [SLOTS-1:0]      hitv;
    logic                  hit;
    logic [SLOT_BITS-1:0]  hidx, top, tgt, rs_n;
    logic                  can_pop, do_pop, do_push, wr_cnt, grab_keyed, clr;
    logic [COUNT_BITS-1:0] cnt_new, ccur;
    logic [1:0]            st_n;
    logic                  ru_n, fr_n, live;
    logic [15:0]           tot_n;

    assign q_pop = q_valid && (!ov_reg || !out_stall);

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            hitv[i] = live_reg[i] && shared_reg[i] && (key_reg[i] == q_req.key);
        hit  = q_req.keyed && (hitv != '0);
        hidx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (hitv[i])
                hidx = SLOT_BITS'(i);
    end

    always_comb
    begin
        can_pop    = (fc_reg != '0);
        top        = stack_reg[SLOT_BITS'(fc_reg - 1'b1)];
        live       = live_reg[q_req.slot];
        ccur       = cnt_reg[q_req.slot];
        do_pop     = 1'b0;
        do_push    = 1'b0;
        wr_cnt     = 1'b0;
        clr        = 1'b0;
        grab_keyed = 1'b0;
        tgt        = q_req.slot;
        cnt_new    = ccur;
        rs_n       = '0;
        st_n       = ST_OK;
        ru_n       = 1'b0;
        fr_n       = 1'b0;
        tot_n      = '0;
        unique case (q_req.mode) inside
            MODE_ALLOC, MODE_KEYED:
            begin
                if (hit)
                begin
                    ru_n = 1'b1;
                    tgt  = hidx;
                    if (cnt_reg[hidx] == CMAX)
                    begin
                        st_n  = ST_SAT;
                        tot_n = 16'(cnt_reg[hidx]);
                    end
                    else
                    begin
                        cnt_new = cnt_reg[hidx] + 1'b1;
                        wr_cnt  = 1'b1;
                        rs_n    = hidx;
                        tot_n   = 16'(cnt_new);
                    end
                end
                else if (can_pop)
                begin
                    do_pop     = 1'b1;
                    grab_keyed = q_req.keyed;
                    rs_n       = top;
                    tot_n      = 16'd1;
                end
                else
                    st_n = ST_NOFREE;
            end
            MODE_RETAIN, MODE_RELEASE, MODE_UNIQUE, MODE_QUERY:
            begin
                if (!live)
                    st_n = ST_DEAD;
                else if (q_req.mode == MODE_RETAIN)
                begin
                    if (ccur == CMAX)
                    begin
                        st_n  = ST_SAT;
                        tot_n = 16'(ccur);
                    end
                    else
                    begin
                        cnt_new = ccur + 1'b1;
                        wr_cnt  = 1'b1;
                        rs_n    = q_req.slot;
                        tot_n   = 16'(cnt_new);
                    end
                end
                else if (q_req.mode == MODE_RELEASE)
                begin
                    rs_n = q_req.slot;
                    if (ccur > COUNT_BITS'(1))
                    begin
                        cnt_new = ccur - 1'b1;
                        wr_cnt  = 1'b1;
                        tot_n   = 16'(cnt_new);
                    end
                    else
                    begin
                        clr     = 1'b1;
                        do_push = (fc_reg != LIVE_BITS'(SLOTS));
                        fr_n    = 1'b1;
                    end
                end
                else if (q_req.mode == MODE_UNIQUE)
                begin
                    if (ccur == COUNT_BITS'(1))
                    begin
                        rs_n  = q_req.slot;
                        tot_n = 16'd1;
                    end
                    else if (can_pop)
                    begin
                        do_pop = 1'b1;
                        rs_n   = top;
                        tot_n  = 16'd1;
                    end
                    else
                    begin
                        st_n  = ST_NOFREE;
                        tot_n = 16'(ccur);
                    end
                end
                else
                begin
                    rs_n  = q_req.slot;
                    tot_n = 16'(ccur);
                end
            end
            default:
            begin
                st_n = ST_OK;
            end
        endcase
        fc_next = fc_reg - LIVE_BITS'(do_pop) + LIVE_BITS'(do_push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                stack_reg[i] <= SLOT_BITS'(SLOTS - 1 - i);
            fc_reg     <= LIVE_BITS'(SLOTS);
            live_reg   <= '0;
            shared_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                fc_reg <= fc_next;
                if (do_push)
                    stack_reg[SLOT_BITS'(fc_reg)] <= q_req.slot;
                if (do_pop)
                begin
                    live_reg[top]   <= 1'b1;
                    shared_reg[top] <= grab_keyed;
                end
                if (clr)
                begin
                    live_reg[q_req.slot]   <= 1'b0;
                    shared_reg[q_req.slot] <= 1'b0;
                end
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (wr_cnt)
                cnt_reg[tgt] <= cnt_new;
            if (do_pop)
            begin
                cnt_reg[top] <= COUNT_BITS'(1);
                key_reg[top] <= grab_keyed ? q_req.key : '0;
            end
            rs_reg  <= rs_n;
            st_reg  <= st_n;
            ru_reg  <= ru_n;
            fr_reg  <= fr_n;
            tot_reg <= tot_n;
        end
    end

    assign out_valid   = ov_reg;
    assign result_slot = rs_reg;
    assign status      = st_reg;
    assign reused      = ru_reg;
    assign user_total  = tot_reg;
    assign slot_freed  = fr_reg;
    assign live_slots  = LIVE_BITS'(SLOTS) - fc_reg;
endmodule
`default_nettype wire
